/* hw/rtl/assert_macros.svh */
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, switched off while reset is asserted
`define MPS_ASSERT_RST(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) prop) \
        else $error("medoid select assertion failed");

// clocked assertion that also holds across reset
`define MPS_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("medoid select assertion failed");

`endif

/* hw/rtl/mps_pkg.sv */
// shared types, constants and helpers of the medoid pixel selector
package mps_pkg;

    localparam int SAMPLE_W      = 16;
    localparam int SAMPLE_FIELDS = 8;
    localparam int SUM_W         = 20;
    localparam int CLIP_W        = 3;
    localparam int CNT_W         = 4;
    localparam int MEM_W         = SAMPLE_W + SUM_W;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 17;
    localparam int DIFF_W        = 17;
    localparam int THRESH_W      = 16;

    typedef logic [SAMPLE_W-1:0] t_sample;
    typedef logic [SUM_W-1:0]    t_sum;
    typedef t_sample [SAMPLE_FIELDS-1:0] t_samples;

    // per-stage load enables shared by the datapath modules
    typedef struct packed {
        logic ld1;
        logic ld2;
        logic ld3;
        logic ld4;
        logic go4;
    } t_pipe_ctl;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CLIP_COUNT    = 3'd0,
        CFG_DIFF_THRESH   = 3'd1,
        CFG_UPDATE_THRESH = 3'd2,
        CFG_NEW_BIAS      = 3'd3,
        CFG_REF_ENABLE    = 3'd4,
        CFG_REF_CLIP      = 3'd5
    } t_cfg_idx;

    // absolute difference of two samples
    function automatic t_sample f_absdiff(t_sample a, t_sample b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

endpackage

/* hw/rtl/mps_lane.sv */
// one lane: sum of absolute differences of its clip against the other active clips
module mps_lane #(
    parameter int LANE  = 0,
    parameter int LANES = 8
) (
    input  logic               i_clk,
    input  mps_pkg::t_pipe_ctl i_ctl,
    input  mps_pkg::t_samples  i_samples,
    input  logic [3:0]         i_active,
    output mps_pkg::t_sum      o_sum
);
    import mps_pkg::*;

    t_sample r_diff [LANES];
    t_sample n_diff [LANES];
    t_sum    r_sum;
    t_sum    n_sum;

    // pairwise differences, masked to active clips other than this one
    always_comb begin
        for (int c = 0; c < LANES; c++) begin
            if (c != LANE && CNT_W'(c) < i_active) begin
                n_diff[c] = f_absdiff(i_samples[LANE], i_samples[c]);
            end else begin
                n_diff[c] = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld1) begin
            r_diff <= n_diff;
        end
    end

    // accumulate the lane sum
    always_comb begin
        n_sum = '0;
        for (int c = 0; c < LANES; c++) begin
            n_sum = n_sum + SUM_W'(r_diff[c]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld2) begin
            r_sum <= n_sum;
        end
    end

    assign o_sum = r_sum;

endmodule

/* hw/rtl/mps_merge.sv */
// merge stage: picks the active lane with the smallest sum, lowest index on a tie
module mps_merge #(
    parameter int LANES = 8
) (
    input  logic                        i_clk,
    input  mps_pkg::t_pipe_ctl          i_ctl,
    input  mps_pkg::t_sum               i_sums [LANES],
    input  logic [3:0]                  i_active,
    output logic [mps_pkg::CLIP_W-1:0]  o_best_idx,
    output mps_pkg::t_sum               o_best_sum
);
    import mps_pkg::*;

    logic [CLIP_W-1:0] r_best_idx;
    logic [CLIP_W-1:0] n_best_idx;
    t_sum              r_best_sum;
    t_sum              n_best_sum;

    // lane 0 is always active; strict compare keeps the lowest index on ties
    always_comb begin
        n_best_idx = '0;
        n_best_sum = i_sums[0];
        for (int r = 1; r < LANES; r++) begin
            if (CNT_W'(r) < i_active && i_sums[r] < n_best_sum) begin
                n_best_sum = i_sums[r];
                n_best_idx = CLIP_W'(r);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld3) begin
            r_best_idx <= n_best_idx;
            r_best_sum <= n_best_sum;
        end
    end

    assign o_best_idx = r_best_idx;
    assign o_best_sum = r_best_sum;

endmodule

/* hw/rtl/mps_recall.sv */
// per-pixel memory: address reduction, clearing pass, reuse decision and update
module mps_recall #(
    parameter int PIXELS = 65536
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  mps_pkg::t_pipe_ctl              i_ctl,
    input  logic [mps_pkg::SAMPLE_W-1:0]    i_pixel_index,
    input  logic [mps_pkg::THRESH_W-1:0]    i_update_thresh,
    input  logic [mps_pkg::THRESH_W-1:0]    i_new_bias,
    input  mps_pkg::t_sample                i_value,
    input  mps_pkg::t_sum                   i_sum,
    output logic                            o_busy,
    output mps_pkg::t_sample                o_value,
    output logic                            o_from_memory
);
    import mps_pkg::*;

    localparam int ADDR_W   = $clog2(PIXELS);
    localparam int EXT_W    = (ADDR_W + 1 > SAMPLE_W + 1) ? ADDR_W + 1 : SAMPLE_W + 1;
    localparam int PROD1_W  = SAMPLE_W + 32;
    localparam int PROD2_W  = SAMPLE_W + $clog2(PIXELS + 1);
    localparam int BSUM_W   = SUM_W + 1;
    localparam logic [31:0] RECIP = 32'((64'd1 << 32) / PIXELS);

    logic [PROD1_W-1:0]  r_prod1;
    logic [SAMPLE_W-1:0] r_idx1;
    logic [PROD2_W-1:0]  r_prod2;
    logic [SAMPLE_W-1:0] r_idx2;
    logic [ADDR_W-1:0]   r_addr3;
    logic [ADDR_W-1:0]   n_addr3;
    logic [ADDR_W-1:0]   r_addr4;
    t_sample             r_val4;
    t_sum                r_sum4;
    logic [MEM_W-1:0]    r_rd;
    logic [MEM_W-1:0]    r_fwd;
    logic                r_hit;
    logic                r_clr_busy;
    logic [ADDR_W-1:0]   r_clr_addr;
    logic [MEM_W-1:0]    r_mem [PIXELS];

    logic [SAMPLE_W-1:0] quot;
    logic [EXT_W-1:0]    rem;
    logic [MEM_W-1:0]    mem_word;
    t_sample             mem_val;
    t_sum                mem_sum;
    t_sample             mem_diff;
    logic [BSUM_W-1:0]   biased_sum;
    logic                mem_on;
    logic                use_mem;
    logic                we_pipe;
    logic                we;
    logic [ADDR_W-1:0]   waddr;
    logic [MEM_W-1:0]    wdata;

    // pixel index modulo PIXELS: reciprocal estimate, back-multiply, one correction
    assign quot = r_prod1[PROD1_W-1:32];

    always_comb begin
        rem = EXT_W'(r_idx2) - EXT_W'(r_prod2);
        if (rem >= EXT_W'(PIXELS)) begin
            rem = rem - EXT_W'(PIXELS);
        end
        n_addr3 = rem[ADDR_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld1) begin
            r_prod1 <= PROD1_W'(i_pixel_index) * PROD1_W'(RECIP);
            r_idx1  <= i_pixel_index;
        end
        if (i_ctl.ld2) begin
            r_prod2 <= PROD2_W'(quot) * PROD2_W'(PIXELS);
            r_idx2  <= r_idx1;
        end
        if (i_ctl.ld3) begin
            r_addr3 <= n_addr3;
        end
        if (i_ctl.ld4) begin
            r_addr4 <= r_addr3;
            r_val4  <= i_value;
            r_sum4  <= i_sum;
            r_fwd   <= {r_val4, r_sum4};
        end
    end

    // bypass for a write to the same pixel at the edge of the read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit <= 1'b0;
        end else if (i_ctl.ld4) begin
            r_hit <= we_pipe && (r_addr4 == r_addr3);
        end
    end

    // reuse decision on the stored value and sum
    always_comb begin
        mem_word   = r_hit ? r_fwd : r_rd;
        mem_val    = mem_word[MEM_W-1:SUM_W];
        mem_sum    = mem_word[SUM_W-1:0];
        mem_diff   = f_absdiff(r_val4, mem_val);
        biased_sum = BSUM_W'(r_sum4) + BSUM_W'(i_new_bias);
        mem_on     = (i_update_thresh != '0);
        use_mem    = mem_on && (mem_diff < i_update_thresh)
                     && (biased_sum > BSUM_W'(mem_sum));
        we_pipe    = i_ctl.go4 && mem_on && !use_mem;
    end

    // clearing pass after reset, one entry per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == ADDR_W'(PIXELS - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    // write port shared by the clearing pass and the update
    always_comb begin
        we    = r_clr_busy || we_pipe;
        waddr = r_clr_busy ? r_clr_addr : r_addr4;
        wdata = r_clr_busy ? {{SAMPLE_W{1'b0}}, {SUM_W{1'b1}}} : {r_val4, r_sum4};
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[waddr] <= wdata;
        end
    end

    // registered read
    always_ff @(posedge i_clk) begin
        if (i_ctl.ld4) begin
            r_rd <= r_mem[r_addr3];
        end
    end

    assign o_busy        = r_clr_busy;
    assign o_value       = use_mem ? mem_val : r_val4;
    assign o_from_memory = use_mem;

endmodule

/* hw/rtl/medoid_pixel_select_with_memory.sv */
// Medoid pixel selector with per-pixel memory, top level. Each transaction
// carries a pixel index and the co-located samples of eight clips; the block
// returns the sample of the clip with the smallest sum of absolute differences
// to the other active clips (lowest index on a tie), optionally replaced by a
// value remembered for that pixel and then by the reference clip's sample.
// One transaction is accepted every cycle while o_stall is low, through the
// seven-deep pipeline of input register, difference lanes, lane sums, merging
// compare, memory read, reuse decision, and reference check with the output
// register. Back-to-back transactions on the same pixel are handled by a
// bypass around the memory. After reset all PIXELS entries (65536 by default)
// of the memory are cleared, during which o_stall is high;
// configuration writes are taken at any time and should be issued while idle.
module medoid_pixel_select_with_memory #(
    parameter int MAX_INPUTS = 8,
    parameter int PIXELS     = 65536
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input channel
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [mps_pkg::SAMPLE_W-1:0]      i_pixel_index,
    input  logic [mps_pkg::SAMPLE_W-1:0]      i_sample_0,
    input  logic [mps_pkg::SAMPLE_W-1:0]      i_sample_1,
    input  logic [mps_pkg::SAMPLE_W-1:0]      i_sample_2,
    input  logic [mps_pkg::SAMPLE_W-1:0]      i_sample_3,
    input  logic [mps_pkg::SAMPLE_W-1:0]      i_sample_4,
    input  logic [mps_pkg::SAMPLE_W-1:0]      i_sample_5,
    input  logic [mps_pkg::SAMPLE_W-1:0]      i_sample_6,
    input  logic [mps_pkg::SAMPLE_W-1:0]      i_sample_7,
    // output channel
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [mps_pkg::SAMPLE_W-1:0]      o_out_value,
    output logic [mps_pkg::CLIP_W-1:0]        o_chosen_clip,
    output logic                              o_from_memory,
    output logic                              o_used_reference,
    // configuration channel
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [mps_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [mps_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import mps_pkg::*;

    localparam int LANES = (MAX_INPUTS < SAMPLE_FIELDS) ? MAX_INPUTS : SAMPLE_FIELDS;

    // configuration registers
    logic [CNT_W-1:0]    r_clip_count;
    logic [DIFF_W-1:0]   r_diff_thresh;
    logic [THRESH_W-1:0] r_update_thresh;
    logic [THRESH_W-1:0] r_new_bias;
    logic                r_ref_enable;
    logic [CLIP_W-1:0]   r_ref_clip;

    // pipeline valids and payload
    logic r_v0, r_v1, r_v2, r_v3, r_v4, r_v5, r_ov;
    logic rdy0, rdy1, rdy2, rdy3, rdy4, rdy5, rdy_o;
    t_pipe_ctl ctl;

    logic [SAMPLE_W-1:0] r_pix0;
    t_samples            in_samples;
    t_samples            r_samp0, r_samp1, r_samp2, r_samp3;
    t_sample             r_ref1, r_ref2, r_ref3, r_ref4, r_ref5;
    logic [CLIP_W-1:0]   r_idx4, r_idx5;
    t_sample             r_res5;
    logic                r_fm5;

    t_sample             r_out_value;
    logic [CLIP_W-1:0]   r_out_clip;
    logic                r_out_fm;
    logic                r_out_ref;

    logic [CNT_W-1:0]    active_cnt;
    t_sum                lane_sums [LANES];
    logic [CLIP_W-1:0]   best_idx;
    t_sum                best_sum;
    t_sample             chosen;
    t_sample             mem_res;
    logic                mem_used;
    logic                clr_busy;
    t_sample             ref_diff;
    logic                use_ref;
    logic                in_take;

    // configuration writes
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clip_count    <= CNT_W'(8);
            r_diff_thresh   <= DIFF_W'(4);
            r_update_thresh <= '0;
            r_new_bias      <= '0;
            r_ref_enable    <= 1'b0;
            r_ref_clip      <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_CLIP_COUNT:    r_clip_count    <= i_cfg_data[CNT_W-1:0];
                CFG_DIFF_THRESH:   r_diff_thresh   <= i_cfg_data[DIFF_W-1:0];
                CFG_UPDATE_THRESH: r_update_thresh <= i_cfg_data[THRESH_W-1:0];
                CFG_NEW_BIAS:      r_new_bias      <= i_cfg_data[THRESH_W-1:0];
                CFG_REF_ENABLE:    r_ref_enable    <= i_cfg_data[0];
                CFG_REF_CLIP:      r_ref_clip      <= i_cfg_data[CLIP_W-1:0];
                default: ;
            endcase
        end
    end

    // active clip count clamped to one..LANES
    always_comb begin
        if (r_clip_count == '0) begin
            active_cnt = CNT_W'(1);
        end else if (r_clip_count > CNT_W'(LANES)) begin
            active_cnt = CNT_W'(LANES);
        end else begin
            active_cnt = r_clip_count;
        end
    end

    // per-stage flow control, a stage loads when empty or moving on
    always_comb begin
        rdy_o   = !r_ov || !i_stall;
        rdy5    = !r_v5 || rdy_o;
        rdy4    = !r_v4 || rdy5;
        rdy3    = !r_v3 || rdy4;
        rdy2    = !r_v2 || rdy3;
        rdy1    = !r_v1 || rdy2;
        rdy0    = !r_v0 || rdy1;
        ctl.ld1 = rdy1;
        ctl.ld2 = rdy2;
        ctl.ld3 = rdy3;
        ctl.ld4 = rdy4;
        ctl.go4 = r_v4 && rdy5;
    end

    assign o_stall = !rdy0 || clr_busy;
    assign in_take = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            if (rdy0)  r_v0 <= in_take;
            if (rdy1)  r_v1 <= r_v0;
            if (rdy2)  r_v2 <= r_v1;
            if (rdy3)  r_v3 <= r_v2;
            if (rdy4)  r_v4 <= r_v3;
            if (rdy5)  r_v5 <= r_v4;
            if (rdy_o) r_ov <= r_v5;
        end
    end

    // input capture and payload carried along the stages
    always_comb begin
        in_samples[0] = i_sample_0;
        in_samples[1] = i_sample_1;
        in_samples[2] = i_sample_2;
        in_samples[3] = i_sample_3;
        in_samples[4] = i_sample_4;
        in_samples[5] = i_sample_5;
        in_samples[6] = i_sample_6;
        in_samples[7] = i_sample_7;
    end

    always_ff @(posedge i_clk) begin
        if (rdy0) begin
            r_pix0  <= i_pixel_index;
            r_samp0 <= in_samples;
        end
        if (rdy1) begin
            r_samp1 <= r_samp0;
            r_ref1  <= r_samp0[r_ref_clip];
        end
        if (rdy2) begin
            r_samp2 <= r_samp1;
            r_ref2  <= r_ref1;
        end
        if (rdy3) begin
            r_samp3 <= r_samp2;
            r_ref3  <= r_ref2;
        end
        if (rdy4) begin
            r_ref4  <= r_ref3;
            r_idx4  <= best_idx;
        end
        if (rdy5) begin
            r_ref5  <= r_ref4;
            r_idx5  <= r_idx4;
            r_res5  <= mem_res;
            r_fm5   <= mem_used;
        end
    end

    // difference lanes
    for (genvar g = 0; g < LANES; g++) begin : g_lane
        mps_lane #(
            .LANE  (g),
            .LANES (LANES)
        ) u_lane (
            .i_clk     (i_clk),
            .i_ctl     (ctl),
            .i_samples (r_samp0),
            .i_active  (active_cnt),
            .o_sum     (lane_sums[g])
        );
    end

    // minimum over the lanes
    mps_merge #(
        .LANES (LANES)
    ) u_merge (
        .i_clk      (i_clk),
        .i_ctl      (ctl),
        .i_sums     (lane_sums),
        .i_active   (active_cnt),
        .o_best_idx (best_idx),
        .o_best_sum (best_sum)
    );

    assign chosen = r_samp3[best_idx];

    // per-pixel memory
    mps_recall #(
        .PIXELS (PIXELS)
    ) u_recall (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctl           (ctl),
        .i_pixel_index   (r_pix0),
        .i_update_thresh (r_update_thresh),
        .i_new_bias      (r_new_bias),
        .i_value         (chosen),
        .i_sum           (best_sum),
        .o_busy          (clr_busy),
        .o_value         (mem_res),
        .o_from_memory   (mem_used)
    );

    // reference fallback and output register
    assign ref_diff = f_absdiff(r_res5, r_ref5);
    assign use_ref  = r_ref_enable && (DIFF_W'(ref_diff) >= r_diff_thresh);

    always_ff @(posedge i_clk) begin
        if (rdy_o) begin
            r_out_value <= use_ref ? r_ref5 : r_res5;
            r_out_clip  <= r_idx5;
            r_out_fm    <= r_fm5;
            r_out_ref   <= use_ref;
        end
    end

    assign o_valid          = r_ov;
    assign o_out_value      = r_out_value;
    assign o_chosen_clip    = r_out_clip;
    assign o_from_memory    = r_out_fm;
    assign o_used_reference = r_out_ref;

endmodule

/* hw/rtl/mps_check.sv */
// port-level checker for the medoid pixel selector, bound to the top level
`include "assert_macros.svh"

module mps_check (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_valid,
    input logic                              o_stall,
    input logic                              o_valid,
    input logic                              i_stall,
    input logic [mps_pkg::SAMPLE_W-1:0]      o_out_value,
    input logic [mps_pkg::CLIP_W-1:0]        o_chosen_clip,
    input logic                              o_from_memory,
    input logic                              o_used_reference
);
    // stages between input and output, the output register included
    localparam int DEPTH = 7;
    localparam int OUT_W = mps_pkg::SAMPLE_W + mps_pkg::CLIP_W + 2;

    logic             in_acc;
    logic             out_acc;
    logic [3:0]       r_cnt;
    logic [OUT_W-1:0] out_word;

    assign in_acc   = i_valid && !o_stall;
    assign out_acc  = o_valid && !i_stall;
    assign out_word = {o_out_value, o_chosen_clip, o_from_memory, o_used_reference};

    // transactions in flight
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= r_cnt + 4'(in_acc) - 4'(out_acc);
        end
    end

    // stalled result holds
    `MPS_ASSERT_RST(a_out_hold, i_clk, i_rst_n, o_valid && i_stall |=> o_valid && $stable(out_word))
    // reset starts the clearing pass with an empty pipeline
    `MPS_ASSERT_ALWAYS(a_reset_clear, i_clk, !i_rst_n |=> o_stall && !o_valid)
    // no result without an accepted transaction behind it
    `MPS_ASSERT_RST(a_no_invented, i_clk, i_rst_n, o_valid |-> r_cnt != 4'd0)
    // occupancy never exceeds the pipeline depth
    `MPS_ASSERT_RST(a_depth, i_clk, i_rst_n, r_cnt <= 4'(DEPTH))

endmodule

bind medoid_pixel_select_with_memory mps_check u_mps_check (.*);

/* sim/medoid_pixel_select_with_memory_test.sv */
// self-checking testbench of the medoid pixel selector with per-pixel memory
`timescale 1ns / 100ps

module medoid_pixel_select_with_memory_test;

    import mps_pkg::*;

    localparam int          CLIP_LIMIT    = 8;
    localparam int          PIXELS        = 65536;
    localparam int unsigned CYCLE_LIMIT   = 1000000;
    localparam int          SETTLE_CYCLES = 20;
    localparam int          RANDOM_PHASES = 10;
    localparam int          PHASE_ITEMS   = 85;
    localparam int          PRINT_LIMIT   = 40;
    // index past the last register, writes to it must be ignored
    localparam logic [CFG_IDX_W-1:0] UNMAPPED_REG = CFG_IDX_W'(CFG_REF_CLIP + 1);

    typedef struct {
        t_sample  pixel;
        t_samples samples;
    } t_pixel_item;

    typedef struct {
        t_sample             out_value;
        logic [CLIP_W-1:0]   chosen_clip;
        logic                from_memory;
        logic                used_reference;
    } t_selection;

    typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} t_stall_mode;

    // clock, reset and block inputs
    logic                   i_clk            = 1'b0;
    logic                   i_rst_n          = 1'b0;
    logic                   i_valid          = 1'b0;
    t_sample                i_pixel_index    = '0;
    t_sample                i_sample_0       = '0;
    t_sample                i_sample_1       = '0;
    t_sample                i_sample_2       = '0;
    t_sample                i_sample_3       = '0;
    t_sample                i_sample_4       = '0;
    t_sample                i_sample_5       = '0;
    t_sample                i_sample_6       = '0;
    t_sample                i_sample_7       = '0;
    logic                   i_stall          = 1'b0;
    logic                   i_cfg_valid      = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_index      = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data       = '0;

    // block outputs
    logic                   o_stall;
    logic                   o_valid;
    t_sample                o_out_value;
    logic [CLIP_W-1:0]      o_chosen_clip;
    logic                   o_from_memory;
    logic                   o_used_reference;
    logic                   o_cfg_ready;

    // shadow copy of the configuration registers
    int unsigned cfg_clip_count    = 8;
    int unsigned cfg_diff_thresh   = 4;
    int unsigned cfg_update_thresh = 0;
    int unsigned cfg_new_bias      = 0;
    int unsigned cfg_ref_enable    = 0;
    int unsigned cfg_ref_clip      = 0;

    // shadow copy of the per-pixel memory
    t_sample value_memory [PIXELS];
    t_sum    sum_memory   [PIXELS];

    t_pixel_item pending_pixels [$];
    t_selection  expected_selections [$];
    t_pixel_item driven_item;
    t_selection  oldest_selection;

    t_sample     pixel_pool [16];
    t_sample     last_queued_pixel = '0;
    bit          sender_bursty     = 1'b0;
    int unsigned burst_left        = 0;
    int unsigned gap_left          = 0;
    t_stall_mode stall_mode        = STALL_NONE;
    int unsigned stall_left        = 0;
    int unsigned mismatch_count    = 0;
    int unsigned cycle_count       = 0;

    medoid_pixel_select_with_memory #(
        .MAX_INPUTS (CLIP_LIMIT),
        .PIXELS     (PIXELS)
    ) DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_pixel_index    (i_pixel_index),
        .i_sample_0       (i_sample_0),
        .i_sample_1       (i_sample_1),
        .i_sample_2       (i_sample_2),
        .i_sample_3       (i_sample_3),
        .i_sample_4       (i_sample_4),
        .i_sample_5       (i_sample_5),
        .i_sample_6       (i_sample_6),
        .i_sample_7       (i_sample_7),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_out_value      (o_out_value),
        .o_chosen_clip    (o_chosen_clip),
        .o_from_memory    (o_from_memory),
        .o_used_reference (o_used_reference),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    // clock
    always #5 i_clk = ~i_clk;

    function automatic int unsigned sample_distance(t_sample a, t_sample b);
        return (a > b) ? int'(a) - int'(b) : int'(b) - int'(a);
    endfunction

    // medoid pick, then memory reuse or refresh, then reference fallback
    function automatic t_selection predict_selection(t_pixel_item it);
        t_selection  sel;
        int unsigned active, row, col, row_sum, best_sum, best_row;
        t_sample     pick, ref_sample;
        active = cfg_clip_count;
        if (active < 1) active = 1;
        if (active > CLIP_LIMIT) active = CLIP_LIMIT;
        best_sum = 0;
        best_row = 0;
        for (row = 0; row < active; row++) begin
            row_sum = 0;
            for (col = 0; col < active; col++)
                if (col != row)
                    row_sum += sample_distance(it.samples[row], it.samples[col]);
            if (row == 0 || row_sum < best_sum) begin
                best_sum = row_sum;
                best_row = row;
            end
        end
        pick = it.samples[best_row];
        sel.from_memory    = 1'b0;
        sel.used_reference = 1'b0;
        if (cfg_update_thresh != 0) begin
            if (sample_distance(pick, value_memory[it.pixel]) < cfg_update_thresh &&
                best_sum + cfg_new_bias > sum_memory[it.pixel]) begin
                pick = value_memory[it.pixel];
                sel.from_memory = 1'b1;
            end else begin
                value_memory[it.pixel] = pick;
                sum_memory[it.pixel]   = best_sum[SUM_W-1:0];
            end
        end
        if (cfg_ref_enable != 0) begin
            ref_sample = it.samples[cfg_ref_clip];
            if (sample_distance(pick, ref_sample) >= cfg_diff_thresh) begin
                pick = ref_sample;
                sel.used_reference = 1'b1;
            end
        end
        sel.out_value   = pick;
        sel.chosen_clip = best_row[CLIP_W-1:0];
        return sel;
    endfunction

    task automatic report_mismatch(string what, int unsigned want, int unsigned got);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT)
            $display("%0t mismatch on %s: expected %0d, got %0d", $realtime, what, want, got);
    endtask

    // one register write on the configuration channel, shadow updated at the handshake
    task automatic write_reg(logic [CFG_IDX_W-1:0] index, int unsigned value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value[CFG_DATA_W-1:0];
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (index)
            CFG_CLIP_COUNT:    cfg_clip_count    = value & 32'hF;
            CFG_DIFF_THRESH:   cfg_diff_thresh   = value & 32'h1FFFF;
            CFG_UPDATE_THRESH: cfg_update_thresh = value & 32'hFFFF;
            CFG_NEW_BIAS:      cfg_new_bias      = value & 32'hFFFF;
            CFG_REF_ENABLE:    cfg_ref_enable    = value & 32'h1;
            CFG_REF_CLIP:      cfg_ref_clip      = value & 32'h7;
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    task automatic apply_settings(int unsigned clips, int unsigned diff, int unsigned upd,
                                  int unsigned bias, int unsigned ref_on, int unsigned ref_idx);
        write_reg(CFG_CLIP_COUNT, clips);
        write_reg(CFG_DIFF_THRESH, diff);
        write_reg(CFG_UPDATE_THRESH, upd);
        write_reg(CFG_NEW_BIAS, bias);
        write_reg(CFG_REF_ENABLE, ref_on);
        write_reg(CFG_REF_CLIP, ref_idx);
    endtask

    task automatic queue_pixel(t_sample px, t_sample s0, t_sample s1, t_sample s2,
                               t_sample s3, t_sample s4, t_sample s5, t_sample s6,
                               t_sample s7);
        t_pixel_item it;
        it.pixel      = px;
        it.samples[0] = s0;
        it.samples[1] = s1;
        it.samples[2] = s2;
        it.samples[3] = s3;
        it.samples[4] = s4;
        it.samples[5] = s5;
        it.samples[6] = s6;
        it.samples[7] = s7;
        pending_pixels.push_back(it);
    endtask

    // sender idle, every transaction answered
    task automatic wait_for_drain();
        do @(negedge i_clk);
        while (pending_pixels.size() != 0 || i_valid || expected_selections.size() != 0);
    endtask

    // mostly revisited pixels and clustered samples so the memory gets reused
    function automatic t_pixel_item random_pixel_item();
        t_pixel_item it;
        int unsigned pick, spread, k;
        int          base, v;
        t_sample     pair_a, pair_b;
        pick = $urandom_range(0, 99);
        if (pick < 15)
            it.pixel = last_queued_pixel;
        else if (pick < 75)
            it.pixel = pixel_pool[$urandom_range(0, 15)];
        else
            it.pixel = t_sample'($urandom);
        last_queued_pixel = it.pixel;
        pick   = $urandom_range(0, 99);
        base   = $urandom_range(0, 65535);
        spread = 1 << $urandom_range(0, 13);
        pair_a = t_sample'($urandom);
        pair_b = t_sample'($urandom);
        for (k = 0; k < SAMPLE_FIELDS; k++) begin
            if (pick < 50) begin
                v = base + int'($urandom_range(0, spread)) - int'(spread / 2);
                if (v < 0) v = 0;
                if (v > 65535) v = 65535;
                it.samples[k] = v[SAMPLE_W-1:0];
            end else if (pick < 70) begin
                it.samples[k] = t_sample'($urandom);
            end else if (pick < 85) begin
                case ($urandom_range(0, 2))
                    0:       it.samples[k] = '0;
                    1:       it.samples[k] = '1;
                    default: it.samples[k] = t_sample'($urandom);
                endcase
            end else begin
                it.samples[k] = $urandom_range(0, 1) ? pair_a : pair_b;
            end
        end
        return it;
    endfunction

    // driver: bursts from the pending queue, prediction at each accepted transaction
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall)
                expected_selections.push_back(predict_selection(driven_item));
            if (!i_valid || !o_stall) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_valid <= 1'b0;
                end else if (pending_pixels.size() > 0) begin
                    driven_item = pending_pixels.pop_front();
                    i_pixel_index <= driven_item.pixel;
                    i_sample_0    <= driven_item.samples[0];
                    i_sample_1    <= driven_item.samples[1];
                    i_sample_2    <= driven_item.samples[2];
                    i_sample_3    <= driven_item.samples[3];
                    i_sample_4    <= driven_item.samples[4];
                    i_sample_5    <= driven_item.samples[5];
                    i_sample_6    <= driven_item.samples[6];
                    i_sample_7    <= driven_item.samples[7];
                    i_valid       <= 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = sender_bursty ? $urandom_range(1, 9) : 0;
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // receiver stall pattern, mode picked at random whenever its run ends
    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode = t_stall_mode'($urandom_range(0, 3));
            stall_left = $urandom_range(16, 96);
        end else begin
            stall_left--;
        end
        case (stall_mode)
            STALL_LIGHT:    i_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY:    i_stall <= ($urandom_range(0, 9) < 7);
            STALL_PERIODIC: i_stall <= stall_left[2];
            default:        i_stall <= 1'b0;
        endcase
    end

    // monitor: compare each accepted result with the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_selections.size() == 0) begin
                report_mismatch("result with nothing expected", 0, o_out_value);
            end else begin
                oldest_selection = expected_selections.pop_front();
                if (o_out_value !== oldest_selection.out_value)
                    report_mismatch("out_value", oldest_selection.out_value, o_out_value);
                if (o_chosen_clip !== oldest_selection.chosen_clip)
                    report_mismatch("chosen_clip", oldest_selection.chosen_clip,
                                    o_chosen_clip);
                if (o_from_memory !== oldest_selection.from_memory)
                    report_mismatch("from_memory", oldest_selection.from_memory,
                                    o_from_memory);
                if (o_used_reference !== oldest_selection.used_reference)
                    report_mismatch("used_reference", oldest_selection.used_reference,
                                    o_used_reference);
            end
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("medoid_pixel_select_with_memory_test: FAIL");
            $finish;
        end
    end

    // reset, directed cases, then random phases under changing settings
    initial begin
        int          addr;
        int unsigned phase, count, clips, diff, upd, bias;
        for (addr = 0; addr < PIXELS; addr++) begin
            value_memory[addr] = '0;
            sum_memory[addr]   = '1;
        end
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset settings: extremes, ties, bit patterns
        queue_pixel(16'd0, 0, 0, 0, 0, 0, 0, 0, 0);
        queue_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                    16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        queue_pixel(16'd1, 0, 16'hFFFF, 0, 16'hFFFF, 0, 16'hFFFF, 0, 16'hFFFF);
        queue_pixel(16'd2, 1234, 1234, 1234, 1234, 1234, 1234, 1234, 1234);
        queue_pixel(16'd3, 100, 200, 300, 400, 500, 600, 700, 800);
        queue_pixel(16'd4, 16'hFFFF, 0, 1, 2, 3, 4, 5, 6);
        queue_pixel(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA,
                    16'h0F0F, 16'hF0F0, 16'h00FF, 16'hFF00);
        wait_for_drain();

        // zero clip count acts as one clip, too many clips saturate
        write_reg(CFG_CLIP_COUNT, 0);
        queue_pixel(16'd5, 900, 10, 10, 10, 10, 10, 10, 10);
        queue_pixel(16'd6, 16'hFFFF, 0, 0, 0, 0, 0, 0, 0);
        wait_for_drain();
        write_reg(UNMAPPED_REG, 32'h1FFFF);
        write_reg(CFG_CLIP_COUNT, 15);
        queue_pixel(16'd7, 7, 60000, 3, 9, 50, 2, 8, 40000);
        wait_for_drain();
        write_reg(CFG_CLIP_COUNT, 1);
        queue_pixel(16'd8, 4321, 0, 0, 0, 0, 0, 0, 0);
        wait_for_drain();
        write_reg(CFG_CLIP_COUNT, 2);
        queue_pixel(16'd9, 300, 100, 0, 0, 0, 0, 0, 0);
        wait_for_drain();

        // memory: first visit writes, close revisit with larger sum reuses
        apply_settings(3, 4, 65535, 0, 0, 0);
        queue_pixel(16'd100, 10, 20, 30, 0, 0, 0, 0, 0);
        queue_pixel(16'd100, 15, 25, 40, 0, 0, 0, 0, 0);
        queue_pixel(16'd100, 20, 20, 20, 0, 0, 0, 0, 0);
        queue_pixel(16'hFFFF, 0, 16'hFFFF, 16'h8000, 0, 0, 0, 0, 0);
        wait_for_drain();
        write_reg(CFG_NEW_BIAS, 65535);
        queue_pixel(16'd100, 500, 520, 540, 0, 0, 0, 0, 0);
        queue_pixel(16'hFFFF, 16'h8000, 16'h8001, 16'h7FFF, 0, 0, 0, 0, 0);
        wait_for_drain();

        // reference fallback: zero threshold, inactive reference clip, top threshold
        apply_settings(2, 0, 0, 0, 1, 7);
        queue_pixel(16'd11, 1, 2, 3, 4, 5, 6, 7, 9999);
        queue_pixel(16'd12, 5, 5, 5, 5, 5, 5, 5, 5);
        wait_for_drain();
        write_reg(CFG_DIFF_THRESH, 65536);
        queue_pixel(16'd13, 0, 0, 0, 0, 0, 0, 0, 16'hFFFF);
        wait_for_drain();
        apply_settings(4, 10, 0, 0, 1, 1);
        queue_pixel(16'd14, 100, 105, 110, 200, 0, 0, 0, 0);
        queue_pixel(16'd15, 100, 120, 101, 102, 0, 0, 0, 0);
        wait_for_drain();

        // random phases, each drained before the next settings
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0: apply_settings(8, 0, 65535, 0, 1, 0);
                1: apply_settings(1, 65536, 1, 65535, 1, 7);
                2: apply_settings(15, 65535, 0, 0, 0, 3);
                3: apply_settings(0, 1, 200, 100, 1, 5);
                default: begin
                    clips = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15)
                                                        : $urandom_range(2, 8);
                    case ($urandom_range(0, 2))
                        0:       diff = $urandom_range(0, 64);
                        1:       diff = $urandom_range(0, 4096);
                        default: diff = $urandom_range(0, 65536);
                    endcase
                    case ($urandom_range(0, 3))
                        0:       upd = 0;
                        1:       upd = $urandom_range(1, 64);
                        2:       upd = $urandom_range(1, 4096);
                        default: upd = $urandom_range(0, 65535);
                    endcase
                    case ($urandom_range(0, 2))
                        0:       bias = 0;
                        1:       bias = $urandom_range(0, 512);
                        default: bias = $urandom_range(0, 65535);
                    endcase
                    apply_settings(clips, diff, upd, bias, $urandom_range(0, 1),
                                   $urandom_range(0, 7));
                end
            endcase
            for (count = 0; count < 16; count++)
                pixel_pool[count] = (count == 0) ? 16'd0 :
                                    (count == 1) ? 16'hFFFF : t_sample'($urandom);
            sender_bursty = (phase == 4) ? 1'b0 : ($urandom_range(0, 3) != 0);
            for (count = 0; count < PHASE_ITEMS; count++)
                pending_pixels.push_back(random_pixel_item());
            wait_for_drain();
        end

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("medoid_pixel_select_with_memory_test: PASS");
        else
            $display("medoid_pixel_select_with_memory_test: FAIL");
        $finish;
    end

endmodule
